// File: hw/rtl/ledpf_pkg.sv
// ----------------------------------------------------------------------------
// ledpf_pkg
// Shared types, constants and color math for the LED strip palette fader.
// ----------------------------------------------------------------------------
package ledpf_pkg;

   localparam int MAX_PIXELS    = 64;
   localparam int FADE_STEPS    = 24;
   localparam int PALETTE_COUNT = 3;
   localparam int INDEX_CYCLE   = 24;

   localparam int PIXEL_ADDR_WIDTH = $clog2(MAX_PIXELS);
   localparam int PIXEL_COUNT_WIDTH = $clog2(MAX_PIXELS + 1);
   localparam int INDEX_WIDTH = 5;
   localparam int PALETTE_WIDTH = 2;
   localparam int NUM_PIXELS_WIDTH = 7;
   localparam int PERIOD_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   // CSR indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUM_PIXELS     = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PALETTE_PERIOD = 1'd1;

   localparam logic [NUM_PIXELS_WIDTH-1:0] NUM_PIXELS_RESET = 7'd56;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd10000;

   // step = diff / FADE_STEPS via reciprocal multiply; exact for 8-bit diffs
   localparam int STEP_SHIFT = 16;
   localparam int STEP_RECIP = (2 ** STEP_SHIFT + FADE_STEPS - 1) / FADE_STEPS;
   localparam int RECIP_WIDTH = STEP_SHIFT + 1;
   localparam int STEP_PROD_WIDTH = 8 + RECIP_WIDTH;

   // channel 0 red, 1 green, 2 blue
   typedef logic [2:0][7:0] rgb_type;

   typedef struct packed {
      rgb_type                cur;
      rgb_type                tgt;
      rgb_type                step;
      logic [INDEX_WIDTH-1:0] idx;
   } pixel_entry_type;

   localparam int ENTRY_WIDTH = $bits(pixel_entry_type);

   typedef struct packed {
      logic [PIXEL_ADDR_WIDTH-1:0] addr;
      logic                        last;
      logic [PALETTE_WIDTH-1:0]    palette;
   } seq_type;

   // {red, green, blue}; slot 3 repeats the rainbow
   localparam logic [23:0] PALETTE_TABLE [0:3][0:7] = '{
      '{24'h400000, 24'h402000, 24'h404000, 24'h004000,
        24'h202020, 24'h000040, 24'h130020, 24'h240040},
      '{24'h300000, 24'h301000, 24'h300000, 24'h301400,
        24'h300000, 24'h300800, 24'h000000, 24'h000000},
      '{24'h202020, 24'h000040, 24'h130020, 24'h240040,
        24'h000000, 24'h000000, 24'h000000, 24'h000000},
      '{24'h400000, 24'h402000, 24'h404000, 24'h004000,
        24'h202020, 24'h000040, 24'h130020, 24'h240040}
   };

   localparam logic [PALETTE_WIDTH-1:0] PAL_RAINBOW = 2'd0;
   localparam logic [PALETTE_WIDTH-1:0] PAL_RED     = 2'd1;
   localparam logic [PALETTE_WIDTH-1:0] PAL_BLUE    = 2'd2;
   localparam logic [PALETTE_WIDTH-1:0] PAL_ALT     = 2'd3;

   function automatic rgb_type unpack_color(logic [23:0] w);
      rgb_type res;
      res[0] = w[23:16];
      res[1] = w[15:8];
      res[2] = w[7:0];
      return res;
   endfunction

   // value below 64 reduced mod 6 by compare-subtract
   function automatic logic [2:0] mod6(logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (r >= 7'd48) r = r - 7'd48;
      if (r >= 7'd24) r = r - 7'd24;
      if (r >= 7'd12) r = r - 7'd12;
      if (r >= 7'd6)  r = r - 7'd6;
      return r[2:0];
   endfunction

   function automatic logic [INDEX_WIDTH-1:0] mod_cycle(logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (r >= 7'd48) r = r - 7'd48;
      if (r >= 7'd24) r = r - 7'd24;
      return r[INDEX_WIDTH-1:0];
   endfunction

   function automatic rgb_type palette_color(logic [PALETTE_WIDTH-1:0] pal,
                                             logic [INDEX_WIDTH-1:0] idx);
      logic [2:0] sel;
      case (pal)
         PAL_RED:  sel = mod6({2'b00, idx});
         PAL_BLUE: sel = {1'b0, idx[1:0]};
         default:  sel = idx[2:0];
      endcase
      return unpack_color(PALETTE_TABLE[pal][sel]);
   endfunction

   function automatic logic [7:0] make_step(logic [7:0] tgt, logic [7:0] cur);
      logic [7:0]                 mag;
      logic [STEP_PROD_WIDTH-1:0] prod;
      logic [7:0]                 q;
      mag  = (tgt >= cur) ? (tgt - cur) : (cur - tgt);
      prod = STEP_PROD_WIDTH'(mag) * STEP_PROD_WIDTH'(STEP_RECIP);
      q    = 8'(prod >> STEP_SHIFT);
      if (q == 8'd0) begin
         return (tgt > cur) ? 8'd1 : 8'hFF;
      end
      return (tgt >= cur) ? q : 8'(-q);
   endfunction

   function automatic logic [7:0] move_channel(logic [7:0] cur, logic [7:0] tgt,
                                               logic [7:0] st);
      logic [7:0] f;
      f = cur + st;
      if (cur > tgt) begin
         if (f > cur || f < tgt) f = tgt;
      end else begin
         if (f < cur || f > tgt) f = tgt;
      end
      return f;
   endfunction

   // start-up contents of one pixel entry: fading within the red palette
   function automatic pixel_entry_type pixel_reset_entry(logic [PIXEL_ADDR_WIDTH-1:0] i);
      pixel_entry_type e;
      logic [2:0]      r;
      logic [2:0]      rn;
      r  = mod6(7'(i));
      rn = (r == 3'd5) ? 3'd0 : r + 3'd1;
      e.cur = unpack_color(PALETTE_TABLE[PAL_RED][r]);
      e.tgt = unpack_color(PALETTE_TABLE[PAL_RED][rn]);
      for (int c = 0; c < 3; c++) begin
         e.step[c] = make_step(e.tgt[c], e.cur[c]);
      end
      e.idx = mod_cycle(7'(i) + 7'd1);
      return e;
   endfunction

endpackage

// File: hw/rtl/ledpf_ram.sv
// ----------------------------------------------------------------------------
// ledpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ledpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ledpf_sequencer.sv
// ----------------------------------------------------------------------------
// ledpf_sequencer
// CSRs, strip pointer, sweep counter and active palette rotation.
// ----------------------------------------------------------------------------
module ledpf_sequencer
   import ledpf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [PERIOD_WIDTH-1:0]     csr_data,
   input  logic                        tick_take,
   output seq_type                     seq
);

   logic [NUM_PIXELS_WIDTH-1:0]  num_pixels_ff, num_pixels_in;
   logic [PERIOD_WIDTH-1:0]      period_ff, period_in;
   logic [PIXEL_ADDR_WIDTH-1:0]  pointer_ff, pointer_in;
   logic [PERIOD_WIDTH-1:0]      sweep_count_ff, sweep_count_in;
   logic [PALETTE_WIDTH-1:0]     palette_ff, palette_in;

   logic [PIXEL_COUNT_WIDTH-1:0] count_eff;
   logic [PIXEL_ADDR_WIDTH-1:0]  cur_addr;
   logic                         last;
   logic [PERIOD_WIDTH:0]        sweep_next;
   logic                         rotate;

   always_comb begin
      // out-of-range counts clamp to 1..MAX_PIXELS
      if (num_pixels_ff == '0) begin
         count_eff = PIXEL_COUNT_WIDTH'(1);
      end else if (num_pixels_ff > NUM_PIXELS_WIDTH'(MAX_PIXELS)) begin
         count_eff = PIXEL_COUNT_WIDTH'(MAX_PIXELS);
      end else begin
         count_eff = PIXEL_COUNT_WIDTH'(num_pixels_ff);
      end

      cur_addr = (PIXEL_COUNT_WIDTH'(pointer_ff) >= count_eff) ? '0 : pointer_ff;
      last     = (PIXEL_COUNT_WIDTH'(cur_addr) + PIXEL_COUNT_WIDTH'(1)) >= count_eff;

      sweep_next = {1'b0, sweep_count_ff} + (PERIOD_WIDTH+1)'(1);
      rotate     = (period_ff != '0 && sweep_next >= {1'b0, period_ff})
                   || sweep_next[PERIOD_WIDTH];

      num_pixels_in  = num_pixels_ff;
      period_in      = period_ff;
      pointer_in     = pointer_ff;
      sweep_count_in = sweep_count_ff;
      palette_in     = palette_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_NUM_PIXELS:     num_pixels_in = csr_data[NUM_PIXELS_WIDTH-1:0];
            CSR_PALETTE_PERIOD: period_in     = csr_data;
            default: ;
         endcase
      end

      if (tick_take) begin
         if (last) begin
            pointer_in = '0;
            if (rotate) begin
               sweep_count_in = '0;
               palette_in = (palette_ff == PALETTE_WIDTH'(PALETTE_COUNT - 1)) ?
                            '0 : palette_ff + PALETTE_WIDTH'(1);
            end else begin
               sweep_count_in = sweep_next[PERIOD_WIDTH-1:0];
            end
         end else begin
            pointer_in = cur_addr + PIXEL_ADDR_WIDTH'(1);
         end
      end

      seq.addr    = cur_addr;
      seq.last    = last;
      seq.palette = palette_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_pixels_ff  <= NUM_PIXELS_RESET;
         period_ff      <= PERIOD_RESET;
         pointer_ff     <= '0;
         sweep_count_ff <= '0;
         palette_ff     <= PAL_RAINBOW;
      end else begin
         num_pixels_ff  <= num_pixels_in;
         period_ff      <= period_in;
         pointer_ff     <= pointer_in;
         sweep_count_ff <= sweep_count_in;
         palette_ff     <= palette_in;
      end
   end

endmodule

// File: hw/rtl/ledpf_pixel_update.sv
// ----------------------------------------------------------------------------
// ledpf_pixel_update
// One fade step of a pixel entry, with retarget when the target is reached.
// ----------------------------------------------------------------------------
module ledpf_pixel_update
   import ledpf_pkg::*;
(
   input  pixel_entry_type          entry,
   input  logic [PALETTE_WIDTH-1:0] palette,
   output pixel_entry_type          entry_next
);

   rgb_type                moved;
   rgb_type                new_tgt;
   logic [INDEX_WIDTH-1:0] new_idx;
   logic                   arrived;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         moved[c] = move_channel(entry.cur[c], entry.tgt[c], entry.step[c]);
      end
      arrived = (moved == entry.tgt);

      new_idx = (entry.idx >= INDEX_WIDTH'(INDEX_CYCLE - 1)) ?
                '0 : entry.idx + INDEX_WIDTH'(1);
      new_tgt = palette_color(palette, new_idx);

      entry_next.cur = moved;
      if (arrived) begin
         entry_next.tgt = new_tgt;
         for (int c = 0; c < 3; c++) begin
            entry_next.step[c] = make_step(new_tgt[c], moved[c]);
         end
         entry_next.idx = new_idx;
      end else begin
         entry_next.tgt  = entry.tgt;
         entry_next.step = entry.step;
         entry_next.idx  = entry.idx;
      end
   end

endmodule

// File: hw/rtl/led_strip_palette_fader_core.sv
// ----------------------------------------------------------------------------
// led_strip_palette_fader_core
// Steps one pixel of an LED strip per tick through palette color fades.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries tick words. A word with req_step_tick high updates the pixel
//   under the strip pointer and yields one rsp_* word (pixel number, new RGB,
//   sweep_end on the last pixel). A word with req_step_tick low is taken and
//   dropped.
//   csr_* writes num_pixels (index 0) and palette_period (index 1). csr_ready
//   is always high; write only while no tick is in flight.
// Path: a taken tick passes the read stage, then the result register, where the receiver takes it.
// Throughput: one tick per cycle unless a stalled result holds the read
//   stage. The pixel store is a RAM with one write and one registered read
//   port; the read is issued at accept, the update and write-back happen in
//   the read stage, and a same-pixel read issued with the write of that pixel
//   (single-pixel strip) is served from the write data.
// Reset: pointer, sweep count and palette clear; every pixel entry reads its
//   start-up value until first written (per-entry valid flags, no clear pass).
// Stall: rsp_stall holds the result register; req_stall rises only when the
//   read stage is full and the result cannot move.
// ----------------------------------------------------------------------------
module led_strip_palette_fader_core
   import ledpf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_step_tick,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [5:0]                  rsp_pixel_number,
   output logic [7:0]                  rsp_red_level,
   output logic [7:0]                  rsp_green_level,
   output logic [7:0]                  rsp_blue_level,
   output logic                        rsp_sweep_end,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [PERIOD_WIDTH-1:0]     csr_data
);

   seq_type                     seq;
   logic                        tick_take;
   logic                        advance;

   // read stage
   logic                        s1_valid_ff, s1_valid_in;
   logic [PIXEL_ADDR_WIDTH-1:0] s1_addr_ff;
   logic                        s1_last_ff;
   logic [PALETTE_WIDTH-1:0]    s1_palette_ff;
   logic                        s1_use_alt_ff;
   pixel_entry_type             s1_alt_ff;

   logic                        fwd_hit;
   logic [MAX_PIXELS-1:0]       written_ff;

   logic                        wr_en;
   logic [ENTRY_WIDTH-1:0]      rd_data;
   pixel_entry_type             entry;
   pixel_entry_type             entry_next;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [5:0]                  rsp_pixel_ff;
   rgb_type                     rsp_color_ff;
   logic                        rsp_last_ff;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign tick_take = req_valid && !req_stall && req_step_tick;
   assign wr_en     = s1_valid_ff && advance;
   assign fwd_hit   = wr_en && (s1_addr_ff == seq.addr);

   ledpf_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .tick_take (tick_take),
      .seq       (seq)
   );

   ledpf_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (MAX_PIXELS)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (entry_next),
      .rd_en   (tick_take),
      .rd_addr (seq.addr),
      .rd_data (rd_data)
   );

   assign entry = s1_use_alt_ff ? s1_alt_ff : pixel_entry_type'(rd_data);

   ledpf_pixel_update u_pixel_update (
      .entry      (entry),
      .palette    (s1_palette_ff),
      .entry_next (entry_next)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (tick_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            written_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_take) begin
         s1_addr_ff    <= seq.addr;
         s1_last_ff    <= seq.last;
         s1_palette_ff <= seq.palette;
         // write landing this edge, or never-written entry
         s1_use_alt_ff <= fwd_hit || !written_ff[seq.addr];
         s1_alt_ff     <= fwd_hit ? entry_next : pixel_reset_entry(seq.addr);
      end
      if (wr_en) begin
         rsp_pixel_ff <= 6'(s1_addr_ff);
         rsp_color_ff <= entry_next.cur;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_number = rsp_pixel_ff;
   assign rsp_red_level    = rsp_color_ff[0];
   assign rsp_green_level  = rsp_color_ff[1];
   assign rsp_blue_level   = rsp_color_ff[2];
   assign rsp_sweep_end    = rsp_last_ff;

endmodule

// File: hw/rtl/ledpf_checker.sv
// ----------------------------------------------------------------------------
// ledpf_checker
// Port-level checks for the palette fader core, bound to the top level.
// ----------------------------------------------------------------------------
module ledpf_checker
   import ledpf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_step_tick,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [5:0]                 rsp_pixel_number,
   input  logic                       rsp_sweep_end
);

   // result word held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_number)
                                 && $stable(rsp_sweep_end))
      else $error("rsp word changed while stalled");

   // a live tick is always followed by a valid result word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_step_tick |-> ##2 rsp_valid)
      else $error("tick without result");

   // input side never blocks while the result register is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req_stall with empty result register");

   // the highest pixel number can only be the end of a sweep
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sweep_end |-> rsp_pixel_number != 6'(MAX_PIXELS - 1))
      else $error("last pixel without sweep_end");

endmodule

bind led_strip_palette_fader_core ledpf_checker u_ledpf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_step_tick    (req_step_tick),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pixel_number (rsp_pixel_number),
   .rsp_sweep_end    (rsp_sweep_end)
);

// File: bench/led_strip_palette_fader_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_palette_fader_core_tb
// Self-checking bench for the palette fader. It runs a few directed ticks on
// the special strip and period settings, then random phases, each of which
// may first write new register settings. Both sides idle at random. Every rsp
// word is checked against an in-bench fader model.
// ----------------------------------------------------------------------------
module led_strip_palette_fader_core_tb;
   import ledpf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TICK_TARGET = 1600;
   localparam int DRAIN_HOLD  = 4;
   localparam int NOISE_PCT   = 10;

   // entry k sits at bits [24*k +: 24], packed {red, green, blue}
   localparam bit [8*24-1:0] RAINBOW_SET = {24'h240040, 24'h130020, 24'h000040,
      24'h202020, 24'h004000, 24'h404000, 24'h402000, 24'h400000};
   localparam bit [6*24-1:0] RED_SET = {24'h300800, 24'h300000, 24'h301400,
      24'h300000, 24'h301000, 24'h300000};
   localparam bit [4*24-1:0] BLUE_SET = {24'h240040, 24'h130020, 24'h000040,
      24'h202020};

   typedef struct {
      bit [5:0] pixel;
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
      bit       sweep_end;
   } pixel_update_type;

   class strip_fade_scoreboard;
      bit [7:0]          level [0:MAX_PIXELS-1][0:2];
      bit [7:0]          goal  [0:MAX_PIXELS-1][0:2];
      bit [7:0]          delta [0:MAX_PIXELS-1][0:2];
      bit [4:0]          slot  [0:MAX_PIXELS-1];
      int unsigned       pointer;
      int unsigned       sweeps;
      bit [1:0]          palette;
      bit [6:0]          strip_len;
      bit [15:0]         period;
      pixel_update_type  pending_updates [$];
      int                errors;

      function new();
         bit [23:0] color;
         errors    = 0;
         pointer   = 0;
         sweeps    = 0;
         palette   = PAL_RAINBOW;
         strip_len = NUM_PIXELS_RESET;
         period    = PERIOD_RESET;
         for (int i = 0; i < MAX_PIXELS; i++) begin
            color = palette_color_of(PAL_RED, i);
            for (int c = 0; c < 3; c++) begin
               level[i][c] = color[23-8*c -: 8];
            end
            aim(i, PAL_RED, i + 1);
         end
      endfunction

      function bit [23:0] palette_color_of(bit [1:0] pal, int unsigned idx);
         case (pal)
            PAL_RED:  return RED_SET[24*(idx % 6) +: 24];
            PAL_BLUE: return BLUE_SET[24*(idx % 4) +: 24];
            default:  return RAINBOW_SET[24*(idx % 8) +: 24];
         endcase
      endfunction

      // truncating divide, never zero
      function bit [7:0] fade_step(bit [7:0] tgt, bit [7:0] cur);
         int q;
         q = (int'(tgt) - int'(cur)) / FADE_STEPS;
         if (q == 0) q = (tgt > cur) ? 1 : -1;
         return q[7:0];
      endfunction

      // wrapping add, clamped to the target from either side
      function bit [7:0] fade_move(bit [7:0] cur, bit [7:0] tgt, bit [7:0] st);
         bit [7:0] sum;
         sum = cur + st;
         if (cur > tgt) begin
            if (sum > cur || sum < tgt) sum = tgt;
         end else if (sum < cur || sum > tgt) begin
            sum = tgt;
         end
         return sum;
      endfunction

      function void aim(int unsigned p, bit [1:0] pal, int unsigned idx);
         bit [23:0] color;
         idx   = idx % INDEX_CYCLE;
         color = palette_color_of(pal, idx);
         for (int c = 0; c < 3; c++) begin
            goal[p][c]  = color[23-8*c -: 8];
            delta[p][c] = fade_step(goal[p][c], level[p][c]);
         end
         slot[p] = idx[4:0];
      endfunction

      function void write_reg(bit [CSR_INDEX_WIDTH-1:0] index, bit [15:0] data);
         case (index)
            CSR_NUM_PIXELS:     strip_len = data[6:0];
            CSR_PALETTE_PERIOD: period = data;
            default: ;
         endcase
      endfunction

      function void note_tick(bit tick);
         int unsigned      n;
         int unsigned      p;
         int unsigned      next;
         bit               last;
         pixel_update_type upd;
         if (!tick) return;
         n = strip_len;
         if (n == 0) n = 1;
         if (n > MAX_PIXELS) n = MAX_PIXELS;
         if (pointer >= n) pointer = 0;
         p = pointer;
         for (int c = 0; c < 3; c++) begin
            level[p][c] = fade_move(level[p][c], goal[p][c], delta[p][c]);
         end
         if (level[p][0] == goal[p][0] && level[p][1] == goal[p][1] &&
             level[p][2] == goal[p][2]) begin
            aim(p, palette, slot[p] + 1);
         end
         last          = (p + 1 >= n);
         upd.pixel     = p[5:0];
         upd.red       = level[p][0];
         upd.green     = level[p][1];
         upd.blue      = level[p][2];
         upd.sweep_end = last;
         pending_updates.push_back(upd);
         if (last) begin
            pointer = 0;
            next    = sweeps + 1;
            // zero period only rotates once the 16-bit count runs out
            if ((period != 0 && next >= period) || next > 16'hFFFF) begin
               sweeps  = 0;
               palette = (palette + 1) % PALETTE_COUNT;
            end else begin
               sweeps = next;
            end
         end else begin
            pointer = p + 1;
         end
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_update(bit [5:0] pixel, bit [7:0] red, bit [7:0] green,
                                 bit [7:0] blue, bit sweep_end);
         pixel_update_type want;
         if (pending_updates.size() == 0) begin
            $display("%0t: unexpected rsp word, expected none, actual pixel %0d",
                     $time, pixel);
            errors++;
            return;
         end
         want = pending_updates.pop_front();
         check_field("pixel_number", want.pixel, pixel);
         check_field("red_level", want.red, red);
         check_field("green_level", want.green, green);
         check_field("blue_level", want.blue, blue);
         check_field("sweep_end", want.sweep_end, sweep_end);
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_step_tick = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [5:0]                 rsp_pixel_number;
   logic [7:0]                 rsp_red_level;
   logic [7:0]                 rsp_green_level;
   logic [7:0]                 rsp_blue_level;
   logic                       rsp_sweep_end;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [PERIOD_WIDTH-1:0]    csr_data = '0;

   strip_fade_scoreboard fader_sb;

   int burst_left = 0;
   bit steady = 1'b0;
   int ticks_sent = 0;
   int stall_left = 0;
   bit stall_phase = 1'b0;
   int cycle_count = 0;

   led_strip_palette_fader_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_step_tick    (req_step_tick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_number (rsp_pixel_number),
      .rsp_red_level    (rsp_red_level),
      .rsp_green_level  (rsp_green_level),
      .rsp_blue_level   (rsp_blue_level),
      .rsp_sweep_end    (rsp_sweep_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            fader_sb.check_update(rsp_pixel_number, rsp_red_level, rsp_green_level,
                                  rsp_blue_level, rsp_sweep_end);
         end
         if (req_valid && !req_stall) fader_sb.note_tick(req_step_tick);
         if (csr_valid && csr_ready) fader_sb.write_reg(csr_index, csr_data);
      end
   end

   // receiver runs in stall runs and free runs, each of random kind and length
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_phase = ($urandom_range(0, 2) == 0);
            stall_left  = stall_phase ? $urandom_range(1, 10) : $urandom_range(1, 40);
         end
         stall_left--;
         rsp_stall <= stall_phase;
      end
   end

   task automatic send_word(input bit tick);
      int gap;
      if (burst_left == 0 && !steady) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid     <= 1'b0;
            req_step_tick <= $urandom_range(0, 1);
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid     <= 1'b1;
      req_step_tick <= tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (tick) ticks_sent++;
   endtask

   // hold the sender until every update is back, then let the pipe empty
   task automatic drain();
      req_valid <= 1'b0;
      // first let the last accepted word reach the queue
      @(posedge clock);
      while (fader_sb.pending_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_HOLD) @(posedge clock);
   endtask

   task automatic csr_write(input bit [CSR_INDEX_WIDTH-1:0] index, input bit [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int npix;
      int period_val;
      int phase_len;
      int sel;
      int phase;
      fader_sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // start-up contents on the default strip, plus an ignored word
      repeat (6) send_word(1'b1);
      send_word(1'b0);
      drain();

      // zero count acts as one pixel; palette rotates every sweep
      csr_write(CSR_NUM_PIXELS, 16'd0);
      csr_write(CSR_PALETTE_PERIOD, 16'd1);
      repeat (4) send_word(1'b1);
      drain();

      // count above the strip size, upper data bits set
      csr_write(CSR_NUM_PIXELS, 16'hFFFF);
      repeat (3) send_word(1'b1);
      drain();

      // shrink the strip under the pointer
      csr_write(CSR_NUM_PIXELS, 16'd2);
      repeat (3) send_word(1'b1);
      drain();

      csr_write(CSR_NUM_PIXELS, 16'd1);
      csr_write(CSR_PALETTE_PERIOD, 16'd0);
      repeat (3) send_word(1'b1);
      drain();
      csr_write(CSR_PALETTE_PERIOD, 16'd50);
      repeat (3) send_word(1'b1);
      drain();
      // period drops below the running sweep count
      csr_write(CSR_PALETTE_PERIOD, 16'd2);
      repeat (2) send_word(1'b1);
      drain();

      phase = 0;
      while (ticks_sent < TICK_TARGET) begin
         if (phase == 0) begin
            npix       = MAX_PIXELS;
            period_val = 1;
         end else begin
            sel = $urandom_range(0, 19);
            if (sel < 14) npix = $urandom_range(1, 8);
            else if (sel < 17) npix = $urandom_range(9, 64);
            else if (sel == 17) npix = 0;
            else npix = $urandom_range(65, 127);
            sel = $urandom_range(0, 19);
            if (sel < 14) period_val = $urandom_range(1, 6);
            else if (sel < 17) period_val = $urandom_range(0, 65535);
            else if (sel == 17) period_val = 0;
            else if (sel == 18) period_val = 65535;
            else period_val = $urandom_range(7, 40);
         end
         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            csr_write(CSR_NUM_PIXELS, 16'(($urandom_range(0, 511) << 7) | npix));
         end
         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            csr_write(CSR_PALETTE_PERIOD, 16'(period_val));
         end
         steady     = ($urandom_range(0, 4) == 0);
         burst_left = 0;
         phase_len  = (phase == 0) ? 160 : $urandom_range(40, 150);
         repeat (phase_len) send_word($urandom_range(0, 99) >= NOISE_PCT);
         drain();
         phase++;
      end

      if (fader_sb.errors == 0) begin
         $display("led_strip_palette_fader_core_tb: PASS");
      end else begin
         $display("led_strip_palette_fader_core_tb: FAIL");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("led_strip_palette_fader_core_tb: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/ledpf_pkg.sv
hw/rtl/ledpf_ram.sv
hw/rtl/ledpf_sequencer.sv
hw/rtl/ledpf_pixel_update.sv
hw/rtl/led_strip_palette_fader_core.sv
hw/rtl/ledpf_checker.sv
bench/led_strip_palette_fader_core_tb.sv
